[hdl/endian_byte_memory_defines.svh]
// ----------------------------------------------------------------------------
// endian_byte_memory_defines.svh
// Assertion macros shared by the endian byte memory modules
// ----------------------------------------------------------------------------
`ifndef ENDIAN_BYTE_MEMORY_DEFINES_SVH
`define ENDIAN_BYTE_MEMORY_DEFINES_SVH

`ifndef SYNTH

// consequent must hold in the same cycle as the antecedent
`define EBM_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define EBM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`else

`define EBM_ASSERT_SAME(label, ante, cons, msg)

`define EBM_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

[hdl/ebm_pkg.sv]
// ----------------------------------------------------------------------------
// ebm_pkg
// Types, codes and helpers shared by the endian byte memory
// ----------------------------------------------------------------------------
package ebm_pkg;

    // default store size in bytes
    localparam int MEM_BYTES_DEF = 65536;

    // byte banks, one per byte lane of a word
    localparam int NUM_BANKS = 4;

    // configuration port
    localparam int CFG_W      = 17;
    localparam int CFG_IDX_W  = 1;
    localparam logic [CFG_IDX_W-1:0] REG_BIG_ENDIAN  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_IN_USE = 1'b1;
    localparam logic [CFG_W-1:0]     SIZE_RESET      = 17'h10000;

    // access kinds and sizes
    localparam logic       MODE_READ   = 1'b0;
    localparam logic       MODE_WRITE  = 1'b1;
    localparam logic [1:0] SZ_BYTE     = 2'd0;
    localparam logic [1:0] SZ_HALF     = 2'd1;
    localparam logic [1:0] SZ_WORD     = 2'd2;
    localparam logic [1:0] SZ_RESERVED = 2'd3;

    // access status passed from the address decode to the pipeline
    typedef struct packed {
        logic       all_ok;
        logic [1:0] offset;
    } t_acc_stat;

    // number of bytes covered by an access size
    function automatic logic [2:0] num_bytes(input logic [1:0] size);
        num_bytes = 3'd1 << size;
    endfunction

    // byte position inside the right-aligned value for access byte k
    function automatic logic [1:0] byte_pos(input logic big, input logic [1:0] size,
                                            input logic [1:0] k);
        logic [2:0] nb;
        nb = num_bytes(size);
        byte_pos = big ? 2'(nb - 3'd1 - {1'b0, k}) : k;
    endfunction

endpackage

[hdl/ebm_bank.sv]
// ----------------------------------------------------------------------------
// ebm_bank
// One byte-wide bank of the store, synchronous write and registered read
// ----------------------------------------------------------------------------
module ebm_bank #(
    parameter int DEPTH = 16384,
    parameter int ROW_W = 14
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic             i_re,
    input  logic [ROW_W-1:0] i_row,
    input  logic [7:0]       i_wdata,
    output logic [7:0]       o_rdata
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_row] <= i_wdata;
        end
    end

    // read port, data held until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_row];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/ebm_addr_map.sv]
// ----------------------------------------------------------------------------
// ebm_addr_map
// Maps one access onto the four byte banks: rows, byte enables, write bytes
// ----------------------------------------------------------------------------
module ebm_addr_map #(
    parameter int MEM_BYTES = ebm_pkg::MEM_BYTES_DEF,
    parameter int ROW_W     = 14
) (
    input  logic                                        i_is_write,
    input  logic [1:0]                                  i_access_size,
    input  logic [31:0]                                 i_address,
    input  logic [31:0]                                 i_write_data,
    input  logic                                        i_big,
    input  logic [ebm_pkg::CFG_W-1:0]                   i_size_in_use,
    output logic [ebm_pkg::NUM_BANKS-1:0]               o_we,
    output logic [ebm_pkg::NUM_BANKS-1:0][ROW_W-1:0]    o_row,
    output logic [ebm_pkg::NUM_BANKS-1:0][7:0]          o_wbyte,
    output ebm_pkg::t_acc_stat                          o_stat
);

    localparam logic [32:0] MEM_LIM = 33'(MEM_BYTES);

    logic [32:0] w_size;
    logic [32:0] w_lim;
    logic [2:0]  w_nbytes;
    logic        w_size_ok;
    logic [32:0] w_end;
    logic        w_all_ok;

    // limit in effect and whole-access range check, no address wrap
    always_comb begin
        w_size    = {16'b0, i_size_in_use};
        w_lim     = (w_size > MEM_LIM) ? MEM_LIM : w_size;
        w_nbytes  = ebm_pkg::num_bytes(i_access_size);
        w_size_ok = (i_access_size != ebm_pkg::SZ_RESERVED);
        w_end     = {1'b0, i_address} + {30'b0, w_nbytes};
        w_all_ok  = w_size_ok && (w_end <= w_lim);
    end

    // per bank: which access byte lands here, its row and its data
    always_comb begin
        logic [1:0]  k;
        logic [1:0]  pos;
        logic [32:0] a;
        logic        in_acc;
        logic        in_lim;
        for (int j = 0; j < ebm_pkg::NUM_BANKS; j++) begin
            k      = 2'(j) - i_address[1:0];
            a      = {1'b0, i_address} + {31'b0, k};
            in_acc = w_size_ok && ({1'b0, k} < w_nbytes);
            in_lim = (a < w_lim);
            pos    = ebm_pkg::byte_pos(i_big, i_access_size, k);
            // big-endian stores the in-range bytes, little-endian all or none
            o_we[j]    = i_is_write && in_acc && (i_big ? in_lim : w_all_ok);
            o_row[j]   = a[ROW_W+1:2];
            o_wbyte[j] = i_write_data[{pos, 3'b000} +: 8];
        end
    end

    assign o_stat.all_ok = w_all_ok;
    assign o_stat.offset = i_address[1:0];

endmodule

[hdl/endian_byte_memory.sv]
// ----------------------------------------------------------------------------
// endian_byte_memory
// Byte-addressed memory with selectable byte order and a size limit
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one access: i_mode
//   (read or write), i_access_size (byte, halfword, word), i_address and
//   i_write_data. Every access produces one transfer on the output channel
//   (o_out_valid / i_out_stall) with o_read_data and o_error.
//   Results are registered through the read stage and then the output
//   stage. One access is accepted every cycle while o_in_stall is low; the
//   store is split into four byte banks, one per lane, so any access of
//   up to four bytes reads or writes each bank once, and the registered
//   bank read port feeds the read stage.
//   Registers are written through i_cfg_we / i_cfg_index / i_cfg_data; the
//   user must write them only while no access is in flight, unchecked here.
//   Reset clears the pipeline and sets little-endian order and a size in
//   use of 65536 bytes; the store content is undefined until written.
//   When the receiver stalls, the result is held and one more access may
//   enter the read stage; after that o_in_stall rises until the output
//   moves.
// ----------------------------------------------------------------------------
`include "endian_byte_memory_defines.svh"

module endian_byte_memory #(
    parameter int MEM_BYTES = ebm_pkg::MEM_BYTES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration writes
    input  logic                              i_cfg_we,
    input  logic [ebm_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [ebm_pkg::CFG_W-1:0]         i_cfg_data,
    // access channel
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_mode,
    input  logic [1:0]                        i_access_size,
    input  logic [31:0]                       i_address,
    input  logic [31:0]                       i_write_data,
    // result channel
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [31:0]                       o_read_data,
    output logic                              o_error
);

    localparam int BANK_DEPTH = (MEM_BYTES + ebm_pkg::NUM_BANKS - 1) / ebm_pkg::NUM_BANKS;
    localparam int ROW_W      = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

    // configuration registers
    logic                        r_big;
    logic [ebm_pkg::CFG_W-1:0]   r_size;

    // read stage
    logic                        r_s1_valid;
    logic                        n_s1_valid;
    logic                        r_s1_write;
    logic                        r_s1_big;
    logic [1:0]                  r_s1_size;
    ebm_pkg::t_acc_stat          r_s1_stat;

    // output stage
    logic                        r_out_valid;
    logic                        n_out_valid;
    logic [31:0]                 r_read_data;
    logic                        r_error;

    logic                        w_out_ready;
    logic                        w_accept;
    logic [ebm_pkg::NUM_BANKS-1:0]              w_we;
    logic [ebm_pkg::NUM_BANKS-1:0]              w_bank_we;
    logic [ebm_pkg::NUM_BANKS-1:0][ROW_W-1:0]   w_row;
    logic [ebm_pkg::NUM_BANKS-1:0][7:0]         w_wbyte;
    logic [ebm_pkg::NUM_BANKS-1:0][7:0]         w_rdata;
    ebm_pkg::t_acc_stat                         w_stat;
    logic [31:0]                 w_value;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_big  <= 1'b0;
            r_size <= ebm_pkg::SIZE_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                ebm_pkg::REG_BIG_ENDIAN:  r_big  <= i_cfg_data[0];
                ebm_pkg::REG_SIZE_IN_USE: r_size <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // handshake
    assign w_out_ready = !r_out_valid || !i_out_stall;
    assign o_in_stall  = r_s1_valid && !w_out_ready;
    assign w_accept    = i_in_valid && !o_in_stall;
    assign n_s1_valid  = w_accept || (r_s1_valid && !w_out_ready);
    assign n_out_valid = w_out_ready ? r_s1_valid : r_out_valid;

    // address decode onto the banks
    ebm_addr_map #(
        .MEM_BYTES (MEM_BYTES),
        .ROW_W     (ROW_W)
    ) u_addr_map (
        .i_is_write    (i_mode == ebm_pkg::MODE_WRITE),
        .i_access_size (i_access_size),
        .i_address     (i_address),
        .i_write_data  (i_write_data),
        .i_big         (r_big),
        .i_size_in_use (r_size),
        .o_we          (w_we),
        .o_row         (w_row),
        .o_wbyte       (w_wbyte),
        .o_stat        (w_stat)
    );

    assign w_bank_we = w_accept ? w_we : '0;

    // four byte banks
    for (genvar g = 0; g < ebm_pkg::NUM_BANKS; g++) begin : g_bank
        ebm_bank #(
            .DEPTH (BANK_DEPTH),
            .ROW_W (ROW_W)
        ) u_bank (
            .i_clk   (i_clk),
            .i_we    (w_bank_we[g]),
            .i_re    (w_accept && (i_mode == ebm_pkg::MODE_READ)),
            .i_row   (w_row[g]),
            .i_wdata (w_wbyte[g]),
            .o_rdata (w_rdata[g])
        );
    end

    // read stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= n_s1_valid;
        end
    end

    // read stage payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_write <= (i_mode == ebm_pkg::MODE_WRITE);
            r_s1_big   <= r_big;
            r_s1_size  <= i_access_size;
            r_s1_stat  <= w_stat;
        end
    end

    // gather bank bytes into the right-aligned value
    always_comb begin
        logic [1:0] k;
        logic [1:0] pos;
        w_value = '0;
        for (int i = 0; i < ebm_pkg::NUM_BANKS; i++) begin
            k   = 2'(i);
            pos = ebm_pkg::byte_pos(r_s1_big, r_s1_size, k);
            if ({1'b0, k} < ebm_pkg::num_bytes(r_s1_size)) begin
                w_value[{pos, 3'b000} +: 8] = w_rdata[r_s1_stat.offset + k];
            end
        end
    end

    // output stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    // output stage payload
    always_ff @(posedge i_clk) begin
        if (w_out_ready && r_s1_valid) begin
            r_read_data <= (!r_s1_write && r_s1_stat.all_ok) ? w_value : 32'b0;
            r_error     <= !r_s1_stat.all_ok;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_read_data = r_read_data;
    assign o_error     = r_error;

    // checks
    `EBM_ASSERT_SAME(a_err_zero, o_out_valid && o_error, o_read_data == 32'b0, "error result carries data")
    `EBM_ASSERT_NEXT(a_accept_s1, w_accept, r_s1_valid, "accepted access missing from read stage")
    `EBM_ASSERT_NEXT(a_s1_hold, r_s1_valid && !w_out_ready, r_s1_valid && $stable(r_s1_stat), "held access lost")
    `EBM_ASSERT_SAME(a_no_write_stalled, o_in_stall, w_bank_we == '0, "bank written while stalled")

endmodule
